// File: sv/prd_pkg.sv
package prd_pkg;

    localparam int WINDOW_HALF = 32;
    localparam int WIN_FULL    = 2 * WINDOW_HALF;
    localparam int IDX_W       = $clog2(WIN_FULL);

    localparam int SAMPLE_W = 16;
    localparam int SPACE_W  = 12;
    localparam int COUNT_W  = 15;
    localparam int SUM_W    = 32;
    localparam int CFG_IDX_W = 2;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [SPACE_W-1:0]         t_space;
    typedef logic [COUNT_W-1:0]         t_count;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    localparam t_cfg_idx CFG_MIN_SPACING  = 2'd0;
    localparam t_cfg_idx CFG_SPACING_SPAN = 2'd1;

    localparam t_space MIN_SPACING_RST  = 12'd400;
    localparam t_space SPACING_SPAN_RST = 12'd100;

    localparam logic signed [MUL_B_W-1:0] LEVEL_COEF  = 18'sh07fe2;
    localparam logic signed [MUL_B_W-1:0] ENERGY_GAIN = 18'sd30;
    localparam logic signed [MUL_B_W-1:0] SPACING_MUL = 18'sh00d55;
    localparam logic signed [PROD_W-1:0]  ROUND_HALF  = 51'sh8000;

    localparam t_count COUNT_MAX  = 15'h7fff;
    localparam t_count RUN_THRESH = COUNT_W'(4 * WINDOW_HALF);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OLD,
        S_RD_BACK,
        S_MXX,
        S_MOO,
        S_MCORR,
        S_MSM,
        S_MEN,
        S_DEC,
        S_FIN
    } t_state;

endpackage

// File: sv/prd_in_if.sv
interface prd_in_if;
    import prd_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    rearm;

    modport source (output valid, output sample, output rearm, input ready);
    modport sink   (input valid, input sample, input rearm, output ready);
endinterface

// File: sv/prd_out_if.sv
interface prd_out_if;
    import prd_pkg::*;

    logic   valid;
    logic   ready;
    logic   detected;
    logic   reversal_now;
    t_space spacing;
    t_count reversal_count;

    modport source (output valid, output detected, output reversal_now, output spacing,
                    output reversal_count, input ready);
    modport sink   (input valid, input detected, input reversal_now, input spacing,
                    input reversal_count, output ready);
endinterface

// File: sv/prd_cfg_if.sv
interface prd_cfg_if;
    import prd_pkg::*;

    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_space   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/prd_mul.sv
module prd_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [prd_pkg::MUL_A_W-1:0]   i_a,
    input  logic signed [prd_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [prd_pkg::PROD_W-1:0]    o_prod
);
    import prd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // product held while idle so the last one can be read later
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;
endmodule

// File: sv/phase_reversal_detector.sv
// Phase reversal detector for an answer tone with reversals.
// Channels: i_in takes one beat per line sample (sample, rearm); o_out returns
// exactly one beat per input beat (detected, reversal_now, spacing,
// reversal_count); i_cfg writes min_spacing (index 0) and spacing_span
// (index 1), always ready, other indexes ignored.
// Timing: a sample beat is taken only while the sequencer is idle; it goes
// through two reads of the window RAM and six uses of the single shared
// multiplier before the result register, and a rearm beat goes straight to
// it. A new beat is taken in the cycle after the result is registered, so no
// sample is taken before the last one is through.
// Reset: synchronous, active low; clears window (per-entry valid bits), sums,
// level, run and count, and loads min_spacing 400, spacing_span 100.
// Rearm clears the same state but keeps the configuration.
// Stall: the result register holds its beat until taken; the sequencer waits
// in its last step, so the next sample waits behind it, and nothing is lost.
// Configuration should be written only while no sample is in flight.
module phase_reversal_detector (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prd_in_if.sink       i_in,
    prd_out_if.source    o_out,
    prd_cfg_if.sink      i_cfg
);
    import prd_pkg::*;

    t_state r_state, n_state;

    // configuration
    t_space r_min;
    t_space r_span;

    // item in flight
    t_sample r_x;
    t_sample r_old;
    t_sample r_w;
    t_idx    r_idx;
    t_idx    r_back;
    logic    r_rev;

    // detector state
    t_idx                   r_wr_idx;
    logic [SUM_W-1:0]       r_corr;
    logic [SUM_W-1:0]       r_energy;
    logic [SUM_W-1:0]       r_smooth;
    t_count                 r_run;
    t_count                 r_total;
    logic                   r_det;
    logic signed [PROD_W-1:0] r_lvl_a;

    // window memory and per-entry valid bits
    t_sample                r_mem [WIN_FULL];
    logic [WIN_FULL-1:0]    r_wvalid;
    t_sample                r_rd;
    logic                   r_rd_vld;
    t_idx                   rd_addr;
    logic                   mem_we;

    // result register
    logic    r_o_valid;
    logic    r_o_det;
    logic    r_o_rev;
    t_space  r_o_space;
    t_count  r_o_count;

    // shared multiplier
    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic                       in_acc;
    logic                       fin_go;
    t_idx                       nxt_idx;
    t_idx                       nxt_back;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic [SUM_W-1:0]           rnd16;
    logic signed [PROD_W-1:0]   level;
    logic signed [PROD_W-1:0]   level_sh;
    logic signed [PROD_W-1:0]   corr2;
    logic                       rev_hit;
    t_space                     space_val;
    logic [SPACE_W:0]           upper;
    logic                       in_range;

    prd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign in_acc = i_in.valid && i_in.ready;
    assign fin_go = !r_o_valid || o_out.ready;

    // next write slot and the slot half a window behind it
    assign nxt_idx  = (r_wr_idx == t_idx'(WIN_FULL - 1)) ? '0 : r_wr_idx + 1'b1;
    assign nxt_back = (nxt_idx >= t_idx'(WINDOW_HALF)) ? nxt_idx - t_idx'(WINDOW_HALF)
                                                      : nxt_idx + t_idx'(WINDOW_HALF);

    assign diff     = $signed({r_x[SAMPLE_W-1], r_x}) - $signed({r_old[SAMPLE_W-1], r_old});
    assign prod_rnd = prod + ROUND_HALF;
    assign rnd16    = SUM_W'(prod_rnd >>> 16);

    // level = smoothed*coef + energy*gain, full width
    assign level    = r_lvl_a + prod;
    assign level_sh = level >>> 17;
    assign corr2    = $signed({{(PROD_W-SUM_W-1){r_corr[SUM_W-1]}}, r_corr, 1'b0});
    assign rev_hit  = (corr2 < level_sh) && (r_run > RUN_THRESH);

    // spacing = run*0xd55 >> 15, run below 2^15 so it fits 12 bits
    assign space_val = r_rev ? prod[15 +: SPACE_W] : '0;
    assign upper     = {1'b0, r_min} + {1'b0, r_span};
    assign in_range  = ({1'b0, space_val} >= {1'b0, r_min}) && ({1'b0, space_val} <= upper);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        mul_en     = 1'b1;
        mul_a      = '0;
        mul_b      = '0;
        mem_we     = 1'b0;
        rd_addr    = r_back;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                mul_en     = 1'b0;
                if (in_acc) begin
                    n_state = i_in.rearm ? S_FIN : S_RD_OLD;
                end
            end
            S_RD_OLD: begin
                mul_en  = 1'b0;
                rd_addr = r_idx;
                n_state = S_RD_BACK;
            end
            S_RD_BACK: begin
                mul_en  = 1'b0;
                n_state = S_MXX;
            end
            S_MXX: begin
                mul_a   = MUL_A_W'(r_x);
                mul_b   = MUL_B_W'(r_x);
                mem_we  = 1'b1;
                n_state = S_MOO;
            end
            S_MOO: begin
                mul_a   = MUL_A_W'(r_old);
                mul_b   = MUL_B_W'(r_old);
                n_state = S_MCORR;
            end
            S_MCORR: begin
                mul_a   = MUL_A_W'(r_w);
                mul_b   = MUL_B_W'(diff);
                n_state = S_MSM;
            end
            S_MSM: begin
                mul_a   = MUL_A_W'($signed(r_smooth));
                mul_b   = LEVEL_COEF;
                n_state = S_MEN;
            end
            S_MEN: begin
                mul_a   = MUL_A_W'($signed(r_energy));
                mul_b   = ENERGY_GAIN;
                n_state = S_DEC;
            end
            S_DEC: begin
                // run before this decision, used only if a reversal is flagged
                mul_a   = $signed({{(MUL_A_W-COUNT_W){1'b0}}, r_run});
                mul_b   = SPACING_MUL;
                n_state = S_FIN;
            end
            S_FIN: begin
                mul_en = 1'b0;
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                mul_en  = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= MIN_SPACING_RST;
            r_span <= SPACING_SPAN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MIN_SPACING:  r_min  <= i_cfg.data;
                CFG_SPACING_SPAN: r_span <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- window memory ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= r_x;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_in.rearm)) begin
            r_wvalid <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_wvalid[r_idx] <= 1'b1;
            end
            r_rd_vld <= r_wvalid[rd_addr];
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_in.rearm)) begin
            r_wr_idx <= '0;
            r_corr   <= '0;
            r_energy <= '0;
            r_smooth <= '0;
            r_run    <= '0;
            r_total  <= '0;
            r_det    <= 1'b0;
            r_rev    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x    <= i_in.sample;
                        r_idx  <= nxt_idx;
                        r_back <= nxt_back;
                        r_rev  <= 1'b0;
                    end
                end
                S_RD_BACK: begin
                    r_old <= r_rd_vld ? r_rd : '0;
                end
                S_MXX: begin
                    r_w      <= r_rd_vld ? r_rd : '0;
                    r_wr_idx <= r_idx;
                end
                S_MOO:   r_energy <= r_energy + rnd16;
                S_MCORR: r_energy <= r_energy - rnd16;
                S_MSM:   r_corr   <= r_corr + rnd16;
                S_MEN:   r_lvl_a  <= prod;
                S_DEC: begin
                    r_smooth <= level[15 +: SUM_W];
                    if (rev_hit) begin
                        r_rev <= 1'b1;
                        r_run <= '0;
                        if (r_total != COUNT_MAX) begin
                            r_total <= r_total + 1'b1;
                        end
                    end else if (r_run != COUNT_MAX) begin
                        r_run <= r_run + 1'b1;
                    end
                end
                S_FIN: begin
                    if (fin_go && r_rev && in_range && (r_total > t_count'(1))) begin
                        r_det <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_FIN && fin_go) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && fin_go) begin
            r_o_det   <= r_det || (r_rev && in_range && (r_total > t_count'(1)));
            r_o_rev   <= r_rev;
            r_o_space <= space_val;
            r_o_count <= r_total;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.detected       = r_o_det;
    assign o_out.reversal_now   = r_o_rev;
    assign o_out.spacing        = r_o_space;
    assign o_out.reversal_count = r_o_count;
endmodule

// File: dv/phase_reversal_detector_test.sv
// Phase reversal detector testbench.
// A short table of beats covers full-scale samples and rearm. Random tone bursts
// follow: square waves whose polarity flips every 135..220 samples, with noise
// bursts and stray rearms mixed in, over a series of min_spacing/spacing_span
// settings. Every result beat is checked against its typed-in expectation or
// an in-bench tracker of the detector state.
module phase_reversal_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prd_pkg::*;

    // Run control
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 16;      // well past the sample latency
    localparam int RANDOM_ITEMS  = 1800;
    localparam int PHASE_ITEMS   = 300;
    localparam int MAX_PHASES    = 40;

    // Register values after reset
    localparam int DEFAULT_MIN  = 400;
    localparam int DEFAULT_SPAN = 100;

    // Indexes the block has no register behind
    localparam t_cfg_idx CFG_UNUSED_LO = 2'd2;
    localparam t_cfg_idx CFG_UNUSED_HI = 2'd3;

    // Tracker arithmetic
    localparam longint      ROUNDING    = 64'sd32768;
    localparam longint      LEVEL_KEEP  = 64'sd32738;   // 0x7fe2
    localparam longint      ENERGY_WT   = 64'sd30;
    localparam int unsigned SPACE_SCALE = 32'hd55;
    localparam int unsigned SAT_15      = 32767;

    typedef struct packed {
        logic   detected;
        logic   reversal_now;
        t_space spacing;
        t_count count;
    } t_report;

    typedef struct packed {
        logic    rearm;
        t_sample smp;
        logic    typed;     // want holds the result to expect
        t_report want;
    } t_step;

    localparam t_report QUIET = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    prd_in_if  smp_if ();
    prd_out_if rpt_if ();
    prd_cfg_if reg_if ();

    phase_reversal_detector i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_if),
        .o_out   (rpt_if),
        .i_cfg   (reg_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Tracker state: a copy of the detector, stepped once per accepted beat
    t_sample     sample_hist [WIN_FULL];
    int unsigned hist_pos;
    int          corr_acc;
    int          energy_acc;
    int          level_acc;
    int unsigned run_len;
    int unsigned rev_total;
    logic        sticky_det;
    t_space      min_space_reg;
    t_space      span_reg;

    t_report pending_q [$];     // results still owed by the block, oldest first
    int      errors    = 0;
    int      issued    = 0;
    int      cycles    = 0;
    bit      gaps_on   = 1'b1;

    // Directed beats. Everything here lies within the first 128 samples after
    // reset or rearm, so no reversal can fire yet; rearm rows and the opening
    // beats are typed in, the rest go through the tracker.
    t_step directed_plan [20] = '{
        '{1'b0, 16'sd0,      1'b1, QUIET},
        '{1'b0, 16'sh7fff,   1'b1, QUIET},
        '{1'b0, 16'sh8000,   1'b1, QUIET},
        '{1'b0, 16'sh8000,   1'b0, QUIET},
        '{1'b0, 16'sh7fff,   1'b0, QUIET},
        '{1'b0, 16'shffff,   1'b0, QUIET},
        '{1'b0, 16'sd1,      1'b0, QUIET},
        '{1'b0, 16'sh5555,   1'b0, QUIET},
        '{1'b0, 16'shaaaa,   1'b0, QUIET},
        '{1'b1, 16'sh7fff,   1'b1, QUIET},   // rearm, sample ignored
        '{1'b0, 16'sh7fff,   1'b0, QUIET},
        '{1'b0, 16'sh8000,   1'b0, QUIET},
        '{1'b1, 16'sh8000,   1'b1, QUIET},
        '{1'b1, 16'sd0,      1'b1, QUIET},   // rearm back to back
        '{1'b0, 16'sd0,      1'b0, QUIET},
        '{1'b0, 16'sd12345,  1'b0, QUIET},
        '{1'b0, -16'sd12345, 1'b0, QUIET},
        '{1'b0, 16'sh7fff,   1'b0, QUIET},
        '{1'b0, 16'sh7fff,   1'b0, QUIET},
        '{1'b0, 16'sh8000,   1'b0, QUIET}
    };

    function automatic void clear_tracker();
        foreach (sample_hist[i]) sample_hist[i] = '0;
        hist_pos   = 0;
        corr_acc   = 0;
        energy_acc = 0;
        level_acc  = 0;
        run_len    = 0;
        rev_total  = 0;
        sticky_det = 1'b0;
    endfunction

    // One sample through the detector: window energy, lag correlation, smoothed
    // level, then the reversal test on run length and correlation.
    function automatic t_report track_reversal(input t_sample x, input logic rearm);
        t_report     rpt;
        int unsigned nxt;
        int unsigned lag;
        t_sample     oldest;
        t_sample     lagged;
        longint      prod;
        longint      lvl;
        logic        hit;
        rpt = QUIET;
        if (rearm) begin
            clear_tracker();
            return rpt;
        end
        nxt    = (hist_pos + 1) % WIN_FULL;
        lag    = (nxt >= WINDOW_HALF) ? nxt - WINDOW_HALF : nxt + WINDOW_HALF;
        oldest = sample_hist[nxt];
        lagged = sample_hist[lag];

        energy_acc += int'((longint'(x) * longint'(x) + ROUNDING) >>> 16);
        energy_acc -= int'((longint'(oldest) * longint'(oldest) + ROUNDING) >>> 16);

        prod = (longint'(lagged) * (longint'(x) - longint'(oldest)) + ROUNDING) >>> 16;
        corr_acc += int'(prod);

        // level kept wide; only the smoothed value wraps at 32 bits
        lvl       = longint'(level_acc) * LEVEL_KEEP + longint'(energy_acc) * ENERGY_WT;
        level_acc = int'(lvl >>> 15);

        hit = (longint'(corr_acc) * 2 < (lvl >>> 17)) && (run_len > 4 * WINDOW_HALF);
        if (hit) begin
            rpt.spacing = t_space'((run_len * SPACE_SCALE) >> 15);
            run_len     = 0;
            if (rev_total < SAT_15) rev_total++;
            // window check uses the count with this reversal in it
            if (int'(rpt.spacing) >= int'(min_space_reg) &&
                int'(rpt.spacing) <= int'(min_space_reg) + int'(span_reg) &&
                rev_total > 1) begin
                sticky_det = 1'b1;
            end
        end else if (run_len < SAT_15) begin
            run_len++;
        end

        sample_hist[nxt] = x;
        hist_pos         = nxt;

        rpt.detected     = sticky_det;
        rpt.reversal_now = hit;
        rpt.count        = t_count'(rev_total);
        return rpt;
    endfunction

    // Drives one sample beat after a random gap while gaps are on; the expectation
    // is queued at the edge that takes the beat.
    task automatic feed_sample(input t_sample s, input logic rearm, input logic typed,
                               input t_report given);
        int      gap;
        t_report calc;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        smp_if.rearm  <= rearm;
        @(posedge i_clk);
        while (smp_if.ready !== 1'b1) @(posedge i_clk);
        calc = track_reversal(s, rearm);
        pending_q.push_back(typed ? given : calc);
        issued++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_space val);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        @(posedge i_clk);
        while (reg_if.ready !== 1'b1) @(posedge i_clk);
        reg_if.valid <= 1'b0;
        case (idx)
            CFG_MIN_SPACING:  min_space_reg = val;
            CFG_SPACING_SPAN: span_reg      = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stop feeding, let every owed beat come back, then give the sequencer time
    task automatic settle();
        smp_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Square tone with a polarity flip at the end of every segment. Periods
    // divide WINDOW_HALF so the lag correlation runs positive until a flip.
    task automatic play_tone_burst();
        int period;
        int amp;
        int segs;
        int seg_len;
        int polarity;
        int ph;
        int v;
        period   = 4 << $urandom_range(0, 3);
        amp      = $urandom_range(1500, 33500);
        segs     = $urandom_range(2, 6);
        polarity = 1;
        ph       = 0;
        for (int s = 0; s < segs; s++) begin
            seg_len = $urandom_range(135, 220);
            for (int k = 0; k < seg_len; k++) begin
                v = (ph < period / 2) ? amp : -amp;
                v = polarity * v + int'($urandom_range(0, amp / 8)) - amp / 16;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                feed_sample(t_sample'(v), 1'b0, 1'b0, QUIET);
                ph = (ph + 1) % period;
            end
            polarity = -polarity;
        end
    endtask

    task automatic note_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // Result side: random stall per beat while gaps are on, then field by field
    // against the oldest owed result
    initial begin : result_sink
        t_report got;
        t_report want;
        int      stall;
        rpt_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = gaps_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                rpt_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rpt_if.ready <= 1'b1;
            @(posedge i_clk);
            while (rpt_if.valid !== 1'b1) @(posedge i_clk);
            got.detected     = rpt_if.detected;
            got.reversal_now = rpt_if.reversal_now;
            got.spacing      = rpt_if.spacing;
            got.count        = rpt_if.reversal_count;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing owed, actual %p", $time, got);
            end else begin
                want = pending_q.pop_front();
                note_field("detected",       16'(want.detected),     16'(got.detected));
                note_field("reversal_now",   16'(want.reversal_now), 16'(got.reversal_now));
                note_field("spacing",        16'(want.spacing),      16'(got.spacing));
                note_field("reversal_count", 16'(want.count),        16'(got.count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int random_start;
        int phase_end;
        int pick;
        int lo;
        int span;

        i_rst_n       = 1'b0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        smp_if.rearm  = 1'b0;
        reg_if.valid  = 1'b0;
        reg_if.index  = CFG_MIN_SPACING;
        reg_if.data   = '0;
        clear_tracker();
        min_space_reg = t_space'(DEFAULT_MIN);
        span_reg      = t_space'(DEFAULT_SPAN);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats under the reset register values
        foreach (directed_plan[k]) begin
            feed_sample(directed_plan[k].smp, directed_plan[k].rearm,
                        directed_plan[k].typed, directed_plan[k].want);
        end

        // Random phases: extremes of the window first, then narrow windows that
        // tone bursts of this length can land in, now and then anything at all.
        // Every third phase runs with no gaps or stalls on either side.
        phase        = 0;
        random_start = issued;
        while (issued - random_start < RANDOM_ITEMS && phase < MAX_PHASES) begin
            settle();
            case (phase)
                0: begin lo = 0;    span = 4095; end
                1: begin lo = 4095; span = 4095; end   // upper bound past 12 bits
                2: begin lo = 4095; span = 0;    end
                3: begin lo = 0;    span = 0;    end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        lo   = $urandom_range(0, 4095);
                        span = $urandom_range(0, 4095);
                    end else begin
                        lo   = $urandom_range(12, 30);
                        span = $urandom_range(0, 12);
                    end
                end
            endcase
            write_reg(CFG_MIN_SPACING, t_space'(lo));
            write_reg(CFG_SPACING_SPAN, t_space'(span));
            if (phase % 4 == 1) begin
                write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                          t_space'($urandom));
            end
            gaps_on   = (phase % 3 != 2);
            phase_end = issued + PHASE_ITEMS;
            while (issued < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    play_tone_burst();
                end else if (pick < 95) begin
                    repeat ($urandom_range(1, 30))
                        feed_sample(t_sample'($urandom), 1'b0, 1'b0, QUIET);
                end else begin
                    feed_sample(t_sample'($urandom), 1'b1, 1'b0, QUIET);
                end
            end
            phase++;
        end
        gaps_on = 1'b1;

        settle();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
